// ===== src/pea_pkg.sv =====
// Shared constants, codes and width helpers for the point extrapolation block.
`default_nettype none

package pea_pkg;

	// Extra fraction bits carried by the length and the dividend
	localparam int GUARD_BITS = 32;

	// Configuration port
	localparam int                      APB_ADDR_W     = 3;
	localparam logic [APB_ADDR_W-3:0]   REG_DEGEN_MODE = '0;

	// Degenerate handling codes
	localparam logic [3:0] MODE_FAIL      = 4'd0;
	localparam logic [3:0] MODE_SHIFT_POS = 4'd1;
	localparam logic [3:0] MODE_SHIFT_NEG = 4'd2;
	localparam logic [3:0] MODE_ADD_X     = 4'd11;
	localparam logic [3:0] MODE_SUB_X     = 4'd12;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DEGEN    = 2'd1;
	localparam logic [1:0] ST_ZERO_LEN = 2'd2;
	localparam logic [1:0] ST_BAD_MODE = 2'd3;

	// Width of an axis difference, wide enough for the unit shift too
	function automatic int pea_mag_width(input int w, input int f);
		return (w > f) ? w : f + 1;
	endfunction

	// Width of the integer square root of (sum of squares) * 2^(2*GUARD_BITS)
	function automatic int pea_root_width(input int w, input int f);
		return pea_mag_width(w, f) + GUARD_BITS + 1;
	endfunction

	// Edges from the accepting edge to the edge that takes the result
	function automatic int pea_latency(input int w, input int f);
		return 6 + pea_root_width(w, f) + w;
	endfunction

endpackage

`default_nettype wire

// ===== src/pea_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
`default_nettype none

module pea_div_pipe #(
	parameter int LANES = 3,
	parameter int NUM_W = 128,
	parameter int DEN_W = 81,
	parameter int QUO_W = 48
) (
	input  wire logic                              clk,
	input  wire logic [LANES-1:0][NUM_W-1:0]       num,
	input  wire logic [DEN_W-1:0]                  den,
	output logic      [LANES-1:0][QUO_W-1:0]       quo
);

	logic [LANES-1:0][DEN_W-1:0] rem_s [QUO_W+1];
	logic [LANES-1:0][QUO_W-1:0] lo_s  [QUO_W+1];
	logic [LANES-1:0][QUO_W-1:0] q_s   [QUO_W+1];
	logic [DEN_W-1:0]            den_s [QUO_W+1];

	// The quotient fits QUO_W bits, so the upper numerator part is below the divisor
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = DEN_W'(num[l] >> QUO_W);
			lo_s[0][l]  = num[l][QUO_W-1:0];
			q_s[0][l]   = '0;
		end
		den_s[0] = den;
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic [LANES-1:0][DEN_W:0] trial;
		logic [LANES-1:0]          ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rem_s[j][l], lo_s[j][l][QUO_W-1]};
				ge[l]    = trial[l] >= {1'b0, den_s[j]};
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[j+1][l] <= ge[l] ? DEN_W'(trial[l] - {1'b0, den_s[j]})
				                       : trial[l][DEN_W-1:0];
				lo_s[j+1][l]  <= lo_s[j][l] << 1;
				q_s[j+1][l]   <= {q_s[j][l][QUO_W-2:0], ge[l]};
			end
			den_s[j+1] <= den_s[j];
		end
	end

	assign quo = q_s[QUO_W];

endmodule

`default_nettype wire

// ===== src/point_extrapolate_along_vector.sv =====
// Top level: extrapolates a 3D point a signed distance beyond P1 along P0->P1.
//
// Usage
//   Input: raise start for one cycle with P0, P1 and the distance on the
//   coordinate ports; the transaction is taken at that edge when busy is low.
//   busy stays low, so a new transaction may be taken at every edge.
//   Output: done is high for exactly one cycle with result_x/y/z and status;
//   the receiver cannot stall and must take the transaction in that cycle.
//   Path: a transaction runs through stages 1 to 4, the square root, the
//   divider and stages 5 and 6; R = mag width + 33 is the square-root width
//   (R is 81 at the defaults). Throughput: one transaction per cycle, set
//   by the pipelined square root (one root bit per stage) and the shared
//   pipelined divider (one quotient bit per stage, three lanes).
//   Configuration: degenerate_mode at byte address 0 of the APB port;
//   write it only while no transaction is in flight.
//   Reset: arst_n clears the mode register and every valid bit; data in the
//   pipeline is dropped and no result is shown for it.
`default_nettype none

module point_extrapolate_along_vector
	import pea_pkg::*;
#(
	parameter int COORD_WIDTH = 48,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [APB_ADDR_W-1:0]         paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] start_z,
	input  wire logic signed [COORD_WIDTH-1:0] next_x,
	input  wire logic signed [COORD_WIDTH-1:0] next_y,
	input  wire logic signed [COORD_WIDTH-1:0] next_z,
	input  wire logic signed [COORD_WIDTH-1:0] distance,
	output logic                               done,
	output logic signed [COORD_WIDTH-1:0]      result_x,
	output logic signed [COORD_WIDTH-1:0]      result_y,
	output logic signed [COORD_WIDTH-1:0]      result_z,
	output logic [1:0]                         status
);

	localparam int W  = COORD_WIDTH;
	localparam int MW = pea_mag_width(COORD_WIDTH, FRAC_BITS);
	localparam int H  = (MW + 1) / 2;        // low half of a split operand
	localparam int HB = MW - H;              // high half
	localparam int PW = 2 * MW;              // full product
	localparam int SW = PW + 2;              // sum of three squares
	localparam int RW = pea_root_width(COORD_WIDTH, FRAC_BITS);
	localparam int NW = PW + GUARD_BITS;     // dividend
	localparam int QW = COORD_WIDTH;         // quotient

	localparam logic [W-1:0]  SIGN_BIT = {1'b1, {(W-1){1'b0}}};
	localparam logic [MW-1:0] ONE      = MW'(1) << FRAC_BITS;

	// Control and coordinates that travel alongside the arithmetic
	typedef struct packed {
		logic [2:0][W-1:0] un;      // P1, sign-flipped (offset binary)
		logic [2:0]        on;      // sign of each axis offset
		logic              bshift;  // unit shift of P1 in X is pending
		logic              bneg;    // direction of that shift
		logic              direct;  // X already final, skip extrapolation
		logic [1:0]        status;
	} tail_t;

	// Add a signed magnitude to an offset-binary coordinate, clamp to range
	function automatic logic [W-1:0] sat_apply(input logic [W-1:0] u, input logic ng,
	                                          input logic [MW:0] m);
		logic [MW+1:0] sum;
		if (!ng) begin
			sum = (MW+2)'(u) + (MW+2)'(m);
			return (sum[MW+1:W] != '0) ? '1 : sum[W-1:0];
		end
		sum = (MW+2)'(u) - (MW+2)'(m);
		return sum[MW+1] ? '0 : sum[W-1:0];
	endfunction

	//------------------------------------------------------------------
	// Configuration register
	//------------------------------------------------------------------
	logic [3:0] mode_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[APB_ADDR_W-1:2] == REG_DEGEN_MODE);
	assign prdata = 32'(mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FAIL;
		end else if (cfg_wr) begin
			mode_q <= pwdata[3:0];
		end
	end

	//------------------------------------------------------------------
	// Stage 1: offset-binary coordinates, axis differences, |distance|
	//------------------------------------------------------------------
	logic                take;
	logic [2:0][W-1:0]   us_c, un_c;
	logic [2:0][MW-1:0]  mag_c;
	logic [2:0]          neg_c;
	logic [W-1:0]        dist_u, dmag_c;

	assign busy   = 1'b0;
	assign take   = start && !busy;
	assign dist_u = distance;

	always_comb begin
		us_c[0] = start_x ^ SIGN_BIT;
		us_c[1] = start_y ^ SIGN_BIT;
		us_c[2] = start_z ^ SIGN_BIT;
		un_c[0] = next_x ^ SIGN_BIT;
		un_c[1] = next_y ^ SIGN_BIT;
		un_c[2] = next_z ^ SIGN_BIT;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = un_c[i] < us_c[i];
			mag_c[i] = neg_c[i] ? MW'(us_c[i] - un_c[i]) : MW'(un_c[i] - us_c[i]);
		end
		dmag_c = dist_u[W-1] ? (~dist_u + W'(1)) : dist_u;
	end

	logic                v_s1;
	logic [2:0][W-1:0]   un_s1;
	logic [2:0][MW-1:0]  mag_s1;
	logic [2:0]          neg_s1;
	logic [W-1:0]        dmag_s1;
	logic                dneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		un_s1   <= un_c;
		mag_s1  <= mag_c;
		neg_s1  <= neg_c;
		dmag_s1 <= dmag_c;
		dneg_s1 <= dist_u[W-1];
	end

	//------------------------------------------------------------------
	// Stage 2: degenerate handling, split partial products
	//------------------------------------------------------------------
	logic                degen;
	logic [2:0][MW-1:0]  mag2_c;
	tail_t               tail2_c;
	logic [MW-1:0]       opa [6];
	logic [MW-1:0]       opb [6];

	assign degen = (mag_s1[0] == '0) && (mag_s1[1] == '0);

	always_comb begin
		mag2_c         = mag_s1;
		tail2_c.un     = un_s1;
		tail2_c.on     = neg_s1 ^ {3{dneg_s1}};
		tail2_c.bshift = 1'b0;
		tail2_c.bneg   = 1'b0;
		tail2_c.direct = 1'b0;
		tail2_c.status = ST_OK;
		if (degen) begin
			unique case (mode_q)
				MODE_FAIL: begin
					tail2_c.status = ST_DEGEN;
				end
				MODE_SHIFT_POS: begin
					mag2_c[0]      = ONE;
					tail2_c.on[0]  = dneg_s1;
					tail2_c.bshift = 1'b1;
				end
				MODE_SHIFT_NEG: begin
					mag2_c[0]      = ONE;
					tail2_c.on[0]  = !dneg_s1;
					tail2_c.bshift = 1'b1;
					tail2_c.bneg   = 1'b1;
				end
				MODE_ADD_X, MODE_SUB_X: begin
					tail2_c.direct = 1'b1;
					tail2_c.un[0]  = sat_apply(un_s1[0],
					                           (mode_q == MODE_SUB_X) ? !dneg_s1 : dneg_s1,
					                           (MW+1)'(dmag_s1));
				end
				default: begin
					tail2_c.status = ST_BAD_MODE;
				end
			endcase
		end
		if (tail2_c.status == ST_OK && !tail2_c.direct && mag2_c == '0) begin
			tail2_c.status = ST_ZERO_LEN;
		end
		// Squares first, then each axis times |distance|
		for (int i = 0; i < 3; i++) begin
			opa[i]   = mag2_c[i];
			opb[i]   = mag2_c[i];
			opa[i+3] = mag2_c[i];
			opb[i+3] = MW'(dmag_s1);
		end
	end

	logic                v_s2;
	tail_t               tail_s2;
	logic [2*H-1:0]      pll_s2 [6];
	logic [H+HB-1:0]     plh_s2 [6];
	logic [H+HB-1:0]     phl_s2 [6];
	logic [2*HB-1:0]     phh_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tail_s2 <= tail2_c;
		for (int k = 0; k < 6; k++) begin
			pll_s2[k] <= opa[k][H-1:0]  * opb[k][H-1:0];
			plh_s2[k] <= opa[k][H-1:0]  * opb[k][MW-1:H];
			phl_s2[k] <= opa[k][MW-1:H] * opb[k][H-1:0];
			phh_s2[k] <= opa[k][MW-1:H] * opb[k][MW-1:H];
		end
	end

	//------------------------------------------------------------------
	// Stage 3: assemble full products
	//------------------------------------------------------------------
	logic            v_s3;
	tail_t           tail_s3;
	logic [PW-1:0]   prod_s3 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tail_s3 <= tail_s2;
		for (int k = 0; k < 6; k++) begin
			prod_s3[k] <= PW'(pll_s2[k]) + ((PW'(plh_s2[k]) + PW'(phl_s2[k])) << H) +
			              (PW'(phh_s2[k]) << (2 * H));
		end
	end

	//------------------------------------------------------------------
	// Stage 4: squared length
	//------------------------------------------------------------------
	logic                v_s4;
	tail_t               tail_s4;
	logic [SW-1:0]       sum_s4;
	logic [2:0][PW-1:0]  cr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tail_s4 <= tail_s3;
		sum_s4  <= SW'(prod_s3[0]) + SW'(prod_s3[1]) + SW'(prod_s3[2]);
		for (int i = 0; i < 3; i++) begin
			cr_s4[i] <= prod_s3[i+3];
		end
	end

	//------------------------------------------------------------------
	// Square root: one root bit per stage over sum * 2^(2*GUARD_BITS)
	//------------------------------------------------------------------
	logic [RW+1:0]       rt_rem_s  [RW+1];
	logic [RW-1:0]       rt_root_s [RW+1];
	logic [SW-1:0]       rt_sum_s  [RW+1];
	logic [2:0][PW-1:0]  rt_cr_s   [RW+1];
	tail_t               rt_tail_s [RW+1];
	logic                rt_v_s    [RW+1];

	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_sum_s[0]  = sum_s4;
	assign rt_cr_s[0]   = cr_s4;
	assign rt_tail_s[0] = tail_s4;
	assign rt_v_s[0]    = v_s4;

	for (genvar j = 0; j < RW; j++) begin : g_root
		logic [2*RW-1:0] rad;
		logic [1:0]      pair;
		logic [RW+1:0]   remsh;
		logic [RW+1:0]   trial;
		logic            ge;

		always_comb begin
			rad   = (2*RW)'(rt_sum_s[j]) << (2 * GUARD_BITS);
			pair  = rad[2*(RW-1-j) +: 2];
			remsh = {rt_rem_s[j][RW-1:0], pair};
			trial = {rt_root_s[j], 2'b01};
			ge    = remsh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j+1] <= 1'b0;
			end else begin
				rt_v_s[j+1] <= rt_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rt_rem_s[j+1]  <= ge ? (remsh - trial) : remsh;
			rt_root_s[j+1] <= {rt_root_s[j][RW-2:0], ge};
			rt_sum_s[j+1]  <= rt_sum_s[j];
			rt_cr_s[j+1]   <= rt_cr_s[j];
			rt_tail_s[j+1] <= rt_tail_s[j];
		end
	end

	//------------------------------------------------------------------
	// Division: |d| * |distance| * 2^GUARD_BITS / root, three lanes
	//------------------------------------------------------------------
	logic [2:0][NW-1:0]  dv_num;
	logic [2:0][QW-1:0]  dv_quo;
	tail_t               dv_tail_s [QW+1];
	logic                dv_v_s    [QW+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_num[i] = NW'(rt_cr_s[RW][i]) << GUARD_BITS;
		end
	end

	pea_div_pipe #(
		.LANES (3),
		.NUM_W (NW),
		.DEN_W (RW),
		.QUO_W (QW)
	) u_div (
		.clk (clk),
		.num (dv_num),
		.den (rt_root_s[RW]),
		.quo (dv_quo)
	);

	assign dv_tail_s[0] = rt_tail_s[RW];
	assign dv_v_s[0]    = rt_v_s[RW];

	// Hold the side data level with the divider stages
	for (genvar j = 0; j < QW; j++) begin : g_div_tail
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_tail_s[j+1] <= dv_tail_s[j];
		end
	end

	//------------------------------------------------------------------
	// Stage 5: fold the unit shift into the X offset
	//------------------------------------------------------------------
	tail_t               dv_tail;
	logic [2:0]          off_neg_c;
	logic [2:0][MW:0]    off_mag_c;
	logic [MW:0]         q_x;
	logic [MW:0]         one_x;

	assign dv_tail = dv_tail_s[QW];
	assign q_x     = (MW+1)'(dv_quo[0]);
	assign one_x   = (MW+1)'(ONE);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_neg_c[i] = dv_tail.on[i];
			off_mag_c[i] = (MW+1)'(dv_quo[i]);
		end
		if (dv_tail.bshift) begin
			priority if (dv_tail.bneg == dv_tail.on[0]) begin
				off_neg_c[0] = dv_tail.bneg;
				off_mag_c[0] = one_x + q_x;
			end else if (one_x >= q_x) begin
				off_neg_c[0] = dv_tail.bneg;
				off_mag_c[0] = one_x - q_x;
			end else begin
				off_neg_c[0] = dv_tail.on[0];
				off_mag_c[0] = q_x - one_x;
			end
		end
	end

	logic                v_s5;
	tail_t               tail_s5;
	logic [2:0]          off_neg_s5;
	logic [2:0][MW:0]    off_mag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		tail_s5    <= dv_tail;
		off_neg_s5 <= off_neg_c;
		off_mag_s5 <= off_mag_c;
	end

	//------------------------------------------------------------------
	// Stage 6: saturating add onto P1, drive the result registers
	//------------------------------------------------------------------
	logic [2:0][W-1:0]   res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			priority if (tail_s5.direct) begin
				res_c[i] = tail_s5.un[i] ^ SIGN_BIT;
			end else if (tail_s5.status != ST_OK) begin
				res_c[i] = '0;
			end else begin
				res_c[i] = sat_apply(tail_s5.un[i], off_neg_s5[i], off_mag_s5[i]) ^ SIGN_BIT;
			end
		end
	end

	logic                done_s6;
	logic [2:0][W-1:0]   res_s6;
	logic [1:0]          status_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s6    <= res_c;
		status_s6 <= tail_s5.status;
	end

	assign done     = done_s6;
	assign result_x = res_s6[0];
	assign result_y = res_s6[1];
	assign result_z = res_s6[2];
	assign status   = status_s6;

endmodule

`default_nettype wire

// ===== src/pea_checker.sv =====
// Port-level checks for the point extrapolation block, bound to the top level.
`default_nettype none

module pea_checker
	import pea_pkg::*;
#(
	parameter int COORD_WIDTH = 48,
	parameter int FRAC_BITS   = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          psel,
	input wire logic                          penable,
	input wire logic                          pwrite,
	input wire logic [APB_ADDR_W-1:0]         paddr,
	input wire logic [31:0]                   pwdata,
	input wire logic [31:0]                   prdata,
	input wire logic                          pready,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic signed [COORD_WIDTH-1:0] start_x,
	input wire logic signed [COORD_WIDTH-1:0] start_y,
	input wire logic signed [COORD_WIDTH-1:0] start_z,
	input wire logic signed [COORD_WIDTH-1:0] next_x,
	input wire logic signed [COORD_WIDTH-1:0] next_y,
	input wire logic signed [COORD_WIDTH-1:0] next_z,
	input wire logic signed [COORD_WIDTH-1:0] distance,
	input wire logic                          done,
	input wire logic signed [COORD_WIDTH-1:0] result_x,
	input wire logic signed [COORD_WIDTH-1:0] result_y,
	input wire logic signed [COORD_WIDTH-1:0] result_z,
	input wire logic [1:0]                    status
);

	localparam int LAT = pea_latency(COORD_WIDTH, FRAC_BITS);

	// Every result traces back to a transaction taken as far back as pea_latency gives
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching start");

	// A failed transaction returns a zero point
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (result_x == '0 && result_y == '0 && result_z == '0))
		else $error("failure status with non-zero point");

	// A non-degenerate pair always has length, so this status never shows
	a_no_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != ST_ZERO_LEN))
		else $error("zero length status reported");

	// A mode write reads back on the next cycle
	a_mode_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_DEGEN_MODE)
		|=> (prdata == 32'($past(pwdata[3:0]))))
		else $error("mode register read back differs from write");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind point_extrapolate_along_vector pea_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.FRAC_BITS   (FRAC_BITS)
) u_pea_checker (.*);

`default_nettype wire

// ===== verif/tb_point_extrapolate_along_vector.sv =====
// Testbench for point_extrapolate_along_vector: self-checking, random and directed.
`default_nettype none

module tb_point_extrapolate_along_vector;
	timeunit 1ns;
	timeprecision 1ps;

	import pea_pkg::*;

	localparam int CW        = 48;
	localparam int FB        = 16;
	localparam int LAT       = pea_latency(CW, FB);
	localparam int CYC_LIMIT = 300000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t sx, sy, sz, nx, ny, nz, span;
	} pair_t;

	typedef struct packed {
		coord_t x, y, z;
		logic [1:0] st;
	} point_t;

	// Extrapolation predictor and queue of pending forecast points
	class forecast_board;
		logic [3:0] mode;
		point_t pending[$];
		int mismatches;

		function new();
			mode = MODE_FAIL;
			mismatches = 0;
		endfunction

		static function coord_t clamp48(logic signed [79:0] v);
			if (v > 80'sh7FFF_FFFF_FFFF)
				return {1'b0, {(CW-1){1'b1}}};
			if (v < -80'sh8000_0000_0000)
				return {1'b1, {(CW-1){1'b0}}};
			return v[CW-1:0];
		endfunction

		static function logic [255:0] root_floor(logic [255:0] n);
			logic [255:0] r, t;
			r = '0;
			for (int b = 127; b >= 0; b--) begin
				t = r | (256'd1 << b);
				if (t * t <= n)
					r = t;
			end
			return r;
		endfunction

		function point_t forecast(pair_t p);
			logic signed [79:0] d[3], nxt[3], off[3], bias, dsig;
			logic [255:0] m[3], dm, s, lg, q;
			logic ng[3];
			logic dn;
			point_t o;
			o = '0;
			o.st = ST_OK;
			nxt[0] = p.nx; nxt[1] = p.ny; nxt[2] = p.nz;
			d[0] = nxt[0] - p.sx; d[1] = nxt[1] - p.sy; d[2] = nxt[2] - p.sz;
			for (int i = 0; i < 3; i++) begin
				ng[i] = d[i] < 0;
				m[i] = ng[i] ? -d[i] : d[i];
			end
			dsig = p.span;
			dn = dsig < 0;
			dm = dn ? -dsig : dsig;
			bias = 0;
			if (d[0] == 0 && d[1] == 0) begin
				case (mode)
					MODE_FAIL: begin
						o.st = ST_DEGEN;
						return o;
					end
					MODE_SHIFT_POS: begin
						ng[0] = 1'b0; m[0] = 256'd1 << FB; bias = 80'sd1 << FB;
					end
					MODE_SHIFT_NEG: begin
						ng[0] = 1'b1; m[0] = 256'd1 << FB; bias = -(80'sd1 << FB);
					end
					MODE_ADD_X, MODE_SUB_X: begin
						o.x = clamp48(mode == MODE_ADD_X ? nxt[0] + dsig : nxt[0] - dsig);
						o.y = p.ny;
						o.z = p.nz;
						return o;
					end
					default: begin
						o.st = ST_BAD_MODE;
						return o;
					end
				endcase
			end
			s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			if (s == 0) begin
				o.st = ST_ZERO_LEN;
				return o;
			end
			lg = root_floor(s << (2 * GUARD_BITS));
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] * dm) << GUARD_BITS) / lg;
				// hold the quotient to 64 bits; the datapath keeps a COORD_WIDTH-bit quotient
				if (q >> 64 != 0)
					q = {192'd0, {64{1'b1}}};
				off[i] = (ng[i] ^ dn) ? -$signed({1'b0, q[78:0]}) : $signed({1'b0, q[78:0]});
			end
			o.x = clamp48(nxt[0] + off[0] + bias);
			o.y = clamp48(nxt[1] + off[1]);
			o.z = clamp48(nxt[2] + off[2]);
			return o;
		endfunction

		function void note(pair_t p);
			pending.push_back(forecast(p));
		endfunction

		function void check(point_t got);
			point_t exp_pt;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h st %0d", got.x, got.y, got.z, got.st);
				return;
			end
			exp_pt = pending.pop_front();
			if (got !== exp_pt) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h %h %h st %0d, got %h %h %h st %0d",
						exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.st,
						got.x, got.y, got.z, got.st);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready, start, busy, done;
	coord_t start_x, start_y, start_z, next_x, next_y, next_z, distance;
	coord_t result_x, result_y, result_z;
	logic [1:0] status;

	forecast_board board;
	int  cycles;
	bit  calm;

	point_extrapolate_along_vector DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.next_x(next_x), .next_y(next_y), .next_z(next_z), .distance(distance),
		.done(done), .result_x(result_x), .result_y(result_y), .result_z(result_z),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sample both sides at the rising edge, before the block's own updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note('{start_x, start_y, start_z, next_x, next_y, next_z, distance});
			if (done)
				board.check('{result_x, result_y, result_z, status});
		end
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Coordinate generator: mostly full range, some small values and extremes
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2, 3: return $signed($urandom_range(0, 1 << 22)) - (coord_t'(1) << 21);
			default: return coord_t'({$urandom, $urandom});
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		p = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord()};
		// make roughly one pair in five degenerate in X and Y
		if ($urandom_range(0, 4) == 0) begin
			p.nx = p.sx;
			p.ny = p.sy;
		end else if ($urandom_range(0, 9) == 0) begin
			// neighbours: a short vector off a random point
			p.nx = p.sx + $signed($urandom_range(0, 8)) - 4;
			p.ny = p.sy + $signed($urandom_range(0, 8)) - 4;
		end
		return p;
	endfunction

	// Present one transaction and hold it until the block takes it
	task automatic send_pair(pair_t p);
		@(negedge clk);
		{start_x, start_y, start_z, next_x, next_y, next_z, distance} = p;
		start = 1'b1;
		do @(posedge clk); while (busy);
		// idle the sender at random, outside the calm stretch
		if (!calm && $urandom_range(0, 99) < 25) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 1)) @(negedge clk);
		end
	endtask

	task automatic write_mode(logic [3:0] m);
		@(negedge clk);
		start  = 1'b0;
		psel   = 1'b1;
		pwrite = 1'b1;
		paddr  = {REG_DEGEN_MODE, 2'b00};
		pwdata = {28'd0, m};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		board.mode = m;
	endtask

	// Let every expected point arrive, then allow for the pipeline depth
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LAT + 8) @(posedge clk);
	endtask

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t ONE  = coord_t'(1) << FB;

	initial begin
		logic [3:0] modes[8];
		board   = new();
		cycles  = 0;
		calm    = 1'b0;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		start   = 1'b0;
		{start_x, start_y, start_z, next_x, next_y, next_z, distance} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed points under the reset mode
		send_pair('{0, 0, 0, 0, 0, 0, 0});
		send_pair('{0, 0, 0, 0, 0, ONE, ONE});
		send_pair('{0, 0, 0, ONE, 0, 0, ONE});
		send_pair('{0, 0, 0, 0, ONE, 0, -ONE});
		send_pair('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX});
		send_pair('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX});
		send_pair('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN});
		send_pair('{CMAX, 0, 0, CMIN, 0, 0, CMIN});
		send_pair('{0, CMIN, 0, 0, CMAX, 0, 0});
		send_pair('{-1, -1, -1, 0, 0, 0, CMAX});
		send_pair('{0, 0, CMIN, 1, 0, CMAX, CMAX});
		send_pair('{ONE, ONE, 0, ONE, ONE, 0, ONE});
		send_pair('{CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX});
		send_pair('{3 * ONE, 4 * ONE, 0, 0, 0, 0, 5 * ONE});
		send_pair('{0, 0, 0, 3, 4, 0, -5});

		modes = '{MODE_FAIL, MODE_SHIFT_POS, MODE_SHIFT_NEG, MODE_ADD_X,
			MODE_SUB_X, 4'd15, 4'd7, MODE_SHIFT_POS};
		foreach (modes[k]) begin
			drain();
			write_mode(modes[k]);
			// degenerate extremes in every mode
			send_pair('{CMAX, CMAX, 0, CMAX, CMAX, CMIN, CMAX});
			send_pair('{CMIN, CMIN, 0, CMIN, CMIN, 0, CMIN});
			send_pair('{CMAX, 0, 0, CMAX, 0, 0, CMIN});
			send_pair('{CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX});
			calm = (k == 3);
			repeat (170) send_pair(rand_pair());
			calm = 1'b0;
		end
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
